// ===== hw/rtl/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Shared sizes and constants of the multichannel moving average block.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int WINDOW      = 100;
    localparam int CHANNELS    = 16;
    localparam int BANKS       = 2;
    localparam int SAMPLE_BITS = 10;

    localparam int BANK_BITS    = 1;
    localparam int CHANNEL_BITS = 4;
    localparam int IN_BITS      = 10;
    localparam int MEAN_BITS    = 10;

    localparam int S_TDATA_BITS = 16;
    localparam int S_TUSER_BITS = BANK_BITS + CHANNEL_BITS;
    localparam int M_TDATA_BITS = 16;

    localparam int NUM_KEYS       = BANKS * CHANNELS;
    localparam int KEY_BITS       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int RING_DEPTH     = NUM_KEYS * WINDOW;
    localparam int RING_ADDR_BITS = $clog2(RING_DEPTH);
    localparam int POS_BITS       = $clog2(WINDOW);
    localparam int SUM_MAX        = WINDOW * ((1 << SAMPLE_BITS) - 1);
    localparam int SUM_BITS       = $clog2(SUM_MAX + 1);
    localparam int STATE_BITS     = SUM_BITS + POS_BITS;

    localparam int RECIP_SHIFT = SUM_BITS + $clog2(WINDOW);
    localparam longint unsigned RECIP_VALUE =
        ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam int PROD_BITS = SUM_BITS + RECIP_SHIFT;

    typedef logic [KEY_BITS-1:0]       t_key;
    typedef logic [RING_ADDR_BITS-1:0] t_ring_addr;
    typedef logic [POS_BITS-1:0]       t_pos;
    typedef logic [SUM_BITS-1:0]       t_sum;
    typedef logic [SAMPLE_BITS-1:0]    t_sample;

endpackage

// ===== hw/rtl/mma_ram.sv =====
// ----------------------------------------------------------------------------
// mma_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/multichannel_moving_average.sv =====
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Boxcar moving average over the last samples of each bank and channel.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one sample word per transfer: tdata holds the
// sample, tuser holds the bank and the channel. The master channel returns
// one mean word for every accepted sample, in the same order.
// Each channel's sample ring lives in one RAM and its running sum and write
// position live in a second RAM. A sample reads its channel state, then its
// oldest ring entry, then writes both back; forwarding from the two newest
// updates lets samples of one channel follow each other in every cycle.
// Throughput is one word per cycle while the receiver keeps up and no sweep
// runs. A sample passes through stages s1, s2 and s3 to the output register
// s4; the divide by the window is a reciprocal multiply in the last stage.
// After reset the block sweeps both RAMs to zero, one ring entry per cycle,
// through all 3200 ring entries; s_tready stays low during the sweep.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps taking samples until its stage before the output is full.
// ----------------------------------------------------------------------------
module multichannel_moving_average (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // sample, zero padding
    input  logic [mma_pkg::S_TDATA_BITS-1:0]    i_s_tdata,
    // bank, channel
    input  logic [mma_pkg::S_TUSER_BITS-1:0]    i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // mean, zero padding
    output logic [mma_pkg::M_TDATA_BITS-1:0]    o_m_tdata
);

    import mma_pkg::*;

    localparam logic [SUM_BITS-1:0]  SumMax = SUM_BITS'(SUM_MAX);
    localparam logic [RECIP_SHIFT-1:0] Recip = RECIP_SHIFT'(RECIP_VALUE);

    logic       r_clr_busy;
    t_ring_addr r_clr_addr;

    logic       r_s1_valid;
    logic       r_s1_hit;
    t_key       r_s1_key;
    t_ring_addr r_s1_base;
    t_sample    r_s1_sample;

    logic       r_s2_valid;
    logic       r_s2_hit;
    t_key       r_s2_key;
    t_sample    r_s2_sample;
    t_pos       r_s2_pos;
    t_sum       r_s2_sum;
    t_ring_addr r_s2_addr;

    logic       r_s3_valid;
    logic       r_s3_hit;
    t_key       r_s3_key;
    t_sum       r_s3_sum;
    t_pos       r_s3_pos;

    logic                 r_s4_valid;
    logic [MEAN_BITS-1:0] r_s4_mean;

    logic       en;
    logic       in_accept;
    logic       in_hit;
    t_key       in_key;
    t_sample    in_sample;

    logic [STATE_BITS-1:0] state_rdata;
    logic [STATE_BITS-1:0] state_wdata;
    logic                  state_we;
    t_key                  state_waddr;

    t_sample    ring_rdata;
    t_sample    ring_wdata;
    logic       ring_we;
    t_ring_addr ring_waddr;
    t_ring_addr ring_raddr;

    t_pos       s1_pos;
    t_sum       s1_sum;
    t_pos       s2_pos_next;
    t_sum       s2_sum_new;
    logic       s2_write;

    logic [PROD_BITS-1:0] s3_prod;
    logic [MEAN_BITS-1:0] s3_mean;

    assign en        = !r_s3_valid || !r_s4_valid || i_m_tready;
    assign o_s_tready = en && !r_clr_busy;
    assign in_accept = i_s_tvalid && o_s_tready;

    assign in_hit    = (int'(i_s_tuser[0]) < BANKS) && (int'(i_s_tuser[4:1]) < CHANNELS);
    assign in_key    = KEY_BITS'(int'(i_s_tuser[0]) * CHANNELS + int'(i_s_tuser[4:1]));
    assign in_sample = SAMPLE_BITS'(i_s_tdata[IN_BITS-1:0]);

    always_comb begin
        if (r_s2_valid && r_s2_hit && (r_s2_key == r_s1_key)) begin
            s1_pos = s2_pos_next;
            s1_sum = s2_sum_new;
        end else if (r_s3_valid && r_s3_hit && (r_s3_key == r_s1_key)) begin
            s1_pos = r_s3_pos;
            s1_sum = r_s3_sum;
        end else begin
            s1_pos = state_rdata[POS_BITS-1:0];
            s1_sum = state_rdata[STATE_BITS-1:POS_BITS];
        end
    end

    assign ring_raddr  = RING_ADDR_BITS'(r_s1_base + RING_ADDR_BITS'(s1_pos));

    assign s2_pos_next = (int'(r_s2_pos) == WINDOW - 1) ? '0 : POS_BITS'(r_s2_pos + 1'b1);
    assign s2_sum_new  = SUM_BITS'(r_s2_sum - SUM_BITS'(ring_rdata) + SUM_BITS'(r_s2_sample));
    assign s2_write    = en && r_s2_valid && r_s2_hit;

    always_comb begin
        if (r_clr_busy) begin
            ring_we     = 1'b1;
            ring_waddr  = r_clr_addr;
            ring_wdata  = '0;
            state_we    = (int'(r_clr_addr) < NUM_KEYS);
            state_waddr = KEY_BITS'(r_clr_addr);
            state_wdata = '0;
        end else begin
            ring_we     = s2_write;
            ring_waddr  = r_s2_addr;
            ring_wdata  = r_s2_sample;
            state_we    = s2_write;
            state_waddr = r_s2_key;
            state_wdata = {s2_sum_new, s2_pos_next};
        end
    end

    mma_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (state_we),
        .i_waddr (state_waddr),
        .i_wdata (state_wdata),
        .i_re    (en),
        .i_raddr (in_key),
        .o_rdata (state_rdata)
    );

    mma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (en),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    assign s3_prod = PROD_BITS'(r_s3_sum) * PROD_BITS'(Recip);
    assign s3_mean = r_s3_hit ? s3_prod[RECIP_SHIFT +: MEAN_BITS] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (int'(r_clr_addr) == RING_DEPTH - 1) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= RING_ADDR_BITS'(r_clr_addr + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (en) begin
                r_s1_valid <= in_accept;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
            end
            if (!r_s4_valid || i_m_tready) begin
                r_s4_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_hit    <= in_hit;
            r_s1_key    <= in_key;
            r_s1_base   <= RING_ADDR_BITS'(int'(in_key) * WINDOW);
            r_s1_sample <= in_sample;

            r_s2_hit    <= r_s1_hit;
            r_s2_key    <= r_s1_key;
            r_s2_sample <= r_s1_sample;
            r_s2_pos    <= s1_pos;
            r_s2_sum    <= s1_sum;
            r_s2_addr   <= ring_raddr;

            r_s3_hit    <= r_s2_hit;
            r_s3_key    <= r_s2_key;
            r_s3_sum    <= s2_sum_new;
            r_s3_pos    <= s2_pos_next;
        end
        if (!r_s4_valid || i_m_tready) begin
            r_s4_mean <= s3_mean;
        end
    end

    assign o_m_tvalid = r_s4_valid;
    assign o_m_tdata  = M_TDATA_BITS'(r_s4_mean);

`ifndef SYNTH
    a_clear_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> (int'($past(r_clr_addr)) == RING_DEPTH - 1))
        else $error("clear sweep ended early");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_hit) |-> (int'(r_s2_pos) < WINDOW))
        else $error("write position out of range");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_hit) |-> (r_s3_sum <= SumMax))
        else $error("running sum out of range");

    a_ring_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_write && r_s1_valid && r_s1_hit) |-> (ring_waddr != ring_raddr))
        else $error("ring read and write hit the same entry");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |=> !r_s1_valid || !$past(r_clr_busy) || !r_clr_busy)
        else $error("word accepted during clear sweep");
`endif

endmodule

// ===== bench/mma_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mma_checker
// Predicts and checks the mean words of the multichannel moving average.
// Every accepted sample word updates a private copy of the per-channel rings,
// sums and write positions. The resulting mean is queued and compared with
// the next mean word the block delivers.
// ----------------------------------------------------------------------------
module mma_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // sample, zero padding
    input  logic [mma_pkg::S_TDATA_BITS-1:0] i_s_tdata,
    // bank, channel
    input  logic [mma_pkg::S_TUSER_BITS-1:0] i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // mean, zero padding
    input  logic [mma_pkg::M_TDATA_BITS-1:0] i_m_tdata,
    output int                               o_errors,
    output int                               o_pending
);

    import mma_pkg::*;

    typedef logic [MEAN_BITS-1:0] t_mean;

    t_sample ring_store [BANKS][CHANNELS][WINDOW];
    t_sum    sum_store  [BANKS][CHANNELS];
    t_pos    pos_store  [BANKS][CHANNELS];
    t_mean   mean_queue [$];
    int      mismatch_count = 0;

    function automatic t_mean advance_window(input int bank, input int chan,
                                             input t_sample sample);
        t_pos pos;
        t_sum sum;
        if (bank >= BANKS || chan >= CHANNELS) begin
            return '0;
        end
        pos = pos_store[bank][chan];
        if (pos >= WINDOW) begin
            pos = '0;
        end
        sum = sum_store[bank][chan] - ring_store[bank][chan][pos] + sample;
        sum_store[bank][chan] = sum;
        ring_store[bank][chan][pos] = sample;
        pos_store[bank][chan] = (pos == t_pos'(WINDOW - 1)) ? t_pos'(0) : pos + 1'b1;
        return t_mean'(sum / WINDOW);
    endfunction

    task automatic report_mismatch(input string what, input t_mean want, input t_mean got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: mean mismatch (%s): expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_mean got;
        t_mean want;
        if (!i_rst_n) begin
            for (int b = 0; b < BANKS; b++) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    sum_store[b][c] = '0;
                    pos_store[b][c] = '0;
                    for (int w = 0; w < WINDOW; w++) begin
                        ring_store[b][c][w] = '0;
                    end
                end
            end
            mean_queue.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[MEAN_BITS-1:0];
                if (mean_queue.size() == 0) begin
                    report_mismatch("no sample outstanding", '0, got);
                end else begin
                    want = mean_queue.pop_front();
                    if (got !== want) begin
                        report_mismatch("wrong value", want, got);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                mean_queue.push_back(advance_window(
                    int'(i_s_tuser[BANK_BITS-1:0]),
                    int'(i_s_tuser[BANK_BITS +: CHANNEL_BITS]),
                    t_sample'(i_s_tdata[IN_BITS-1:0])));
            end
        end
        o_errors  = mismatch_count;
        o_pending = mean_queue.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the multichannel moving average.
// A short directed sequence is followed by random bursts of sample words on
// single channels, mixed with scattered words, across four phases that vary sender
// idling and receiver stalling. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import mma_pkg::*;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    s_tvalid   = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata    = '0;
    logic [S_TUSER_BITS-1:0] s_tuser    = '0;
    logic                    m_tvalid;
    logic                    m_tready   = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    int                      errors;
    int                      pending;
    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    multichannel_moving_average dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    mma_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_sample(input logic [BANK_BITS-1:0] bank,
                               input logic [CHANNEL_BITS-1:0] chan,
                               input t_sample sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'(sample);
        s_tuser  <= {chan, bank};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_bursts(input int count, input bit open_with_full_scale);
        int                      left;
        int                      len;
        int                      style;
        logic [BANK_BITS-1:0]    bank;
        logic [CHANNEL_BITS-1:0] chan;
        t_sample                 sample;
        left = count;
        if (open_with_full_scale) begin
            bank = BANK_BITS'($urandom_range(BANKS - 1));
            chan = CHANNEL_BITS'($urandom_range(CHANNELS - 1));
            for (int i = 0; i < WINDOW + 5; i++) begin
                send_sample(bank, chan, '1);
            end
            left -= WINDOW + 5;
        end
        while (left > 0) begin
            if ($urandom_range(1) == 0) begin
                bank = $urandom_range(1) ? BANK_BITS'(BANKS - 1) : '0;
                chan = bank ? CHANNEL_BITS'(CHANNELS - 1) : CHANNEL_BITS'(3);
            end else begin
                bank = BANK_BITS'($urandom_range(BANKS - 1));
                chan = CHANNEL_BITS'($urandom_range(CHANNELS - 1));
            end
            style = $urandom_range(7);
            len   = ($urandom_range(7) == 0) ? $urandom_range(120, 80) : $urandom_range(40, 1);
            if (len > left) begin
                len = left;
            end
            for (int i = 0; i < len; i++) begin
                case (style)
                    0: begin
                        sample = '1;
                    end
                    1: begin
                        sample = '0;
                    end
                    2: begin
                        sample = SAMPLE_BITS'($urandom_range(1023, 1000));
                    end
                    7: begin
                        bank   = BANK_BITS'($urandom_range(BANKS - 1));
                        chan   = CHANNEL_BITS'($urandom_range(CHANNELS - 1));
                        sample = SAMPLE_BITS'($urandom);
                    end
                    default: begin
                        sample = SAMPLE_BITS'($urandom);
                    end
                endcase
                send_sample(bank, chan, sample);
            end
            left -= len;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_sample(1'b0, 4'd0,  10'd0);
        send_sample(1'b1, 4'd15, 10'd1023);
        send_sample(1'b0, 4'd15, 10'h2AA);
        send_sample(1'b1, 4'd0,  10'h155);
        send_sample(1'b0, 4'd5,  10'd1023);
        send_sample(1'b0, 4'd5,  10'd1023);
        send_sample(1'b0, 4'd5,  10'd1);
        send_sample(1'b0, 4'd5,  10'd512);
        send_sample(1'b0, 4'd5,  10'd0);
        send_sample(1'b1, 4'd1,  10'd99);
        send_sample(1'b1, 4'd2,  10'd100);
        send_sample(1'b1, 4'd4,  10'd101);
        send_sample(1'b1, 4'd8,  10'd1023);
        send_sample(1'b1, 4'd8,  10'd1023);
        send_sample(1'b1, 4'd8,  10'd1023);
        send_sample(1'b0, 4'd5,  10'd700);
        send_sample(1'b1, 4'd8,  10'd0);
        send_sample(1'b0, 4'd0,  10'd1000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 66;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            send_bursts(250, (phase == 0) || (phase == 3));
        end
        s_tvalid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("multichannel_moving_average verification clean");
        end else begin
            $display("multichannel_moving_average verification failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("multichannel_moving_average verification failed");
        $finish;
    end

endmodule
